@@ design/ctb_pkg.sv @@
// ---------------------------------------------------------------------------
// ctb_pkg
// Shared constants and types for the cursor text buffer: command and status
// codes, controller states and the controller/datapath handshake structs.
// ---------------------------------------------------------------------------
package ctb_pkg;

    // Default store depth in bytes
    localparam int CAPACITY_DEF = 1024;

    // Field widths fixed by the interface
    localparam int CMD_W    = 3;
    localparam int CHAR_W   = 8;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LEFT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RIGHT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] STS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] STS_RANGE   = 2'd3;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MOVE
    } ctl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming beat
        logic rd_en;     // issue the store read for this command
        logic finish;    // commit pointers, store write and result
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_read;  // command needs a store read before it commits
        logic slot_free;  // result register can take a new beat
    } dp_status_t;

endpackage

@@ design/cursor_text_buffer_core.sv @@
// ---------------------------------------------------------------------------
// cursor_text_buffer_core
// One-line text buffer with a cursor, held as a gap buffer in a single-port
// byte store of CAPACITY entries. Each beat on the input channel carries one
// command (insert before the cursor, cursor left, cursor right, backspace or
// read at a logical index) and yields exactly one result beat with status,
// length, cursor and the byte read. Insert, backspace, refused and
// out-of-range commands pass through the accept state and the execute
// state, which registers the result. Cursor moves and in-range reads pass
// through a move state as well, since the single store port first reads a
// byte and then writes it across the gap or hands it out. The next beat is
// taken in the cycle after the result is registered. A result waiting on
// out_ready stalls only the commit of the next command, which is already
// accepted; the commit waits until the result is taken. The store needs no
// clearing after reset.
// ---------------------------------------------------------------------------
module cursor_text_buffer_core
#(
    parameter int CAPACITY = ctb_pkg::CAPACITY_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ctb_pkg::CMD_W-1:0]     cmd,
    input  logic [ctb_pkg::CHAR_W-1:0]    char_in,
    input  logic [ctb_pkg::INDEX_W-1:0]   read_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ctb_pkg::STATUS_W-1:0]  status,
    output logic [ctb_pkg::COUNT_W-1:0]   text_length,
    output logic [ctb_pkg::COUNT_W-1:0]   cursor_pos,
    output logic [ctb_pkg::CHAR_W-1:0]    char_out
);

    ctb_pkg::dp_cmd_t    dp_cmd;
    ctb_pkg::dp_status_t dp_sts;

    // Sequencer
    ctb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .dp_sts   (dp_sts),
        .dp_cmd   (dp_cmd)
    );

    // Store, pointers and result register
    ctb_datapath
    #(
        .CAPACITY (CAPACITY)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .dp_sts      (dp_sts),
        .cmd         (cmd),
        .char_in     (char_in),
        .read_index  (read_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .text_length (text_length),
        .cursor_pos  (cursor_pos),
        .char_out    (char_out)
    );

endmodule

@@ design/ctb_ctrl.sv @@
// ---------------------------------------------------------------------------
// ctb_ctrl
// Command sequencer: takes one input beat, runs the store read if the
// command needs one, then commits when the result register is free.
// ---------------------------------------------------------------------------
module ctb_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ctb_pkg::dp_status_t    dp_sts,
    output ctb_pkg::dp_cmd_t       dp_cmd
);

    ctb_pkg::ctl_state_t state_reg;
    ctb_pkg::ctl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ctb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        dp_cmd.capture = 1'b0;
        dp_cmd.rd_en   = 1'b0;
        dp_cmd.finish  = 1'b0;
        case (state_reg)
            ctb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dp_cmd.capture = 1'b1;
                    state_next     = ctb_pkg::ST_EXEC;
                end
            end
            ctb_pkg::ST_EXEC:
            begin
                if (dp_sts.need_read)
                begin
                    dp_cmd.rd_en = 1'b1;
                    state_next   = ctb_pkg::ST_MOVE;
                end
                else if (dp_sts.slot_free)
                begin
                    dp_cmd.finish = 1'b1;
                    state_next    = ctb_pkg::ST_IDLE;
                end
            end
            ctb_pkg::ST_MOVE:
            begin
                if (dp_sts.slot_free)
                begin
                    dp_cmd.finish = 1'b1;
                    state_next    = ctb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ctb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/ctb_datapath.sv @@
// ---------------------------------------------------------------------------
// ctb_datapath
// Gap pointers, single-port byte store, command decode and the result
// register. Moves read one byte and write it across the gap.
// ---------------------------------------------------------------------------
module ctb_datapath
#(
    parameter int CAPACITY = ctb_pkg::CAPACITY_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ctb_pkg::dp_cmd_t              dp_cmd,
    output ctb_pkg::dp_status_t           dp_sts,
    input  logic [ctb_pkg::CMD_W-1:0]     cmd,
    input  logic [ctb_pkg::CHAR_W-1:0]    char_in,
    input  logic [ctb_pkg::INDEX_W-1:0]   read_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ctb_pkg::STATUS_W-1:0]  status,
    output logic [ctb_pkg::COUNT_W-1:0]   text_length,
    output logic [ctb_pkg::COUNT_W-1:0]   cursor_pos,
    output logic [ctb_pkg::CHAR_W-1:0]    char_out
);

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int EW = (PW > ctb_pkg::COUNT_W) ? PW : ctb_pkg::COUNT_W;
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
    localparam logic [EW-1:0] CAP_E = EW'(CAPACITY);

    logic [ctb_pkg::CMD_W-1:0]    cmd_reg;
    logic [ctb_pkg::CHAR_W-1:0]   char_reg;
    logic [ctb_pkg::INDEX_W-1:0]  index_reg;
    logic [PW-1:0]                gs_reg;
    logic [PW-1:0]                gs_next;
    logic [PW-1:0]                ge_reg;
    logic [PW-1:0]                ge_next;
    logic [ctb_pkg::CHAR_W-1:0]   rd_data_reg;
    logic                         out_valid_reg;
    logic [ctb_pkg::STATUS_W-1:0] status_reg;
    logic [ctb_pkg::COUNT_W-1:0]  length_reg;
    logic [ctb_pkg::COUNT_W-1:0]  cursor_reg;
    logic [ctb_pkg::CHAR_W-1:0]   char_out_reg;

    logic [ctb_pkg::CHAR_W-1:0]   mem [CAPACITY];

    logic [ctb_pkg::STATUS_W-1:0] sts_c;
    logic                         need_read_c;
    logic                         wr_c;
    logic                         rd_ok_c;
    logic [PW-1:0]                raddr_c;
    logic [PW-1:0]                waddr_c;
    logic [AW-1:0]                mem_addr;
    logic                         mem_we;
    logic [ctb_pkg::CHAR_W-1:0]   mem_wdata;
    logic [EW-1:0]                gap_e;
    logic [EW-1:0]                len_e;
    logic [EW-1:0]                len_next_e;
    logic [EW-1:0]                idx_e;
    logic [EW-1:0]                phys_e;
    logic [EW-1:0]                gs_next_e;

    // Latch the accepted beat
    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            cmd_reg   <= cmd;
            char_reg  <= char_in;
            index_reg <= read_index;
        end
    end

    // Gap geometry and logical-to-physical mapping for reads
    always_comb
    begin
        gap_e  = EW'(ge_reg) - EW'(gs_reg);
        len_e  = CAP_E - gap_e;
        idx_e  = EW'(index_reg);
        phys_e = (idx_e < EW'(gs_reg)) ? idx_e : idx_e + gap_e;
    end

    // Decode the held command
    always_comb
    begin
        sts_c       = ctb_pkg::STS_DONE;
        need_read_c = 1'b0;
        wr_c        = 1'b0;
        rd_ok_c     = 1'b0;
        raddr_c     = gs_reg;
        waddr_c     = gs_reg;
        gs_next     = gs_reg;
        ge_next     = ge_reg;
        case (cmd_reg)
            ctb_pkg::CMD_INSERT:
            begin
                if (gs_reg != ge_reg)
                begin
                    wr_c    = 1'b1;
                    gs_next = gs_reg + PW'(1);
                end
                else
                begin
                    sts_c = ctb_pkg::STS_FULL;
                end
            end
            ctb_pkg::CMD_LEFT:
            begin
                if (gs_reg != '0)
                begin
                    need_read_c = 1'b1;
                    wr_c        = 1'b1;
                    raddr_c     = gs_reg - PW'(1);
                    waddr_c     = ge_reg - PW'(1);
                    gs_next     = gs_reg - PW'(1);
                    ge_next     = ge_reg - PW'(1);
                end
                else
                begin
                    sts_c = ctb_pkg::STS_IGNORED;
                end
            end
            ctb_pkg::CMD_RIGHT:
            begin
                if (ge_reg != CAP_P)
                begin
                    need_read_c = 1'b1;
                    wr_c        = 1'b1;
                    raddr_c     = ge_reg;
                    waddr_c     = gs_reg;
                    gs_next     = gs_reg + PW'(1);
                    ge_next     = ge_reg + PW'(1);
                end
                else
                begin
                    sts_c = ctb_pkg::STS_IGNORED;
                end
            end
            ctb_pkg::CMD_BACK:
            begin
                if (gs_reg != '0)
                begin
                    gs_next = gs_reg - PW'(1);
                end
                else
                begin
                    sts_c = ctb_pkg::STS_IGNORED;
                end
            end
            ctb_pkg::CMD_READ:
            begin
                if (idx_e < len_e)
                begin
                    need_read_c = 1'b1;
                    rd_ok_c     = 1'b1;
                    raddr_c     = phys_e[PW-1:0];
                end
                else
                begin
                    sts_c = ctb_pkg::STS_RANGE;
                end
            end
            default:
            begin
                sts_c = ctb_pkg::STS_IGNORED;
            end
        endcase
    end

    // Single store port: read address while reading, write address otherwise
    always_comb
    begin
        mem_addr  = dp_cmd.rd_en ? raddr_c[AW-1:0] : waddr_c[AW-1:0];
        mem_we    = dp_cmd.finish && wr_c;
        mem_wdata = (cmd_reg == ctb_pkg::CMD_INSERT) ? char_reg : rd_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.rd_en)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    // Gap pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gs_reg <= '0;
            ge_reg <= CAP_P;
        end
        else if (dp_cmd.finish)
        begin
            gs_reg <= gs_next;
            ge_reg <= ge_next;
        end
    end

    // Result values after the commit
    always_comb
    begin
        gs_next_e  = EW'(gs_next);
        len_next_e = CAP_E - (EW'(ge_next) - EW'(gs_next));
    end

    // Result register: load on commit, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dp_cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.finish)
        begin
            status_reg   <= sts_c;
            length_reg   <= len_next_e[ctb_pkg::COUNT_W-1:0];
            cursor_reg   <= gs_next_e[ctb_pkg::COUNT_W-1:0];
            char_out_reg <= rd_ok_c ? rd_data_reg : '0;
        end
    end

    assign dp_sts.need_read = need_read_c;
    assign dp_sts.slot_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign text_length = length_reg;
    assign cursor_pos  = cursor_reg;
    assign char_out    = char_out_reg;

endmodule
